// ===== rtl/s3f_pkg.sv =====
`timescale 1ns / 1ps
package s3f_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 4096;
    localparam int ColW      = 10;
    localparam int RowW      = 13;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       flush;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       frame_last;
    } t_out_item;

    typedef enum logic [1:0] {
        REG_WIDTH     = 2'd0,
        REG_HEIGHT    = 2'd1,
        REG_MODE      = 2'd2,
        REG_THRESHOLD = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        MODE_BOX     = 3'd0,
        MODE_GAUSS   = 3'd1,
        MODE_SHARPEN = 3'd2,
        MODE_EMBOSS  = 3'd3,
        MODE_SOBEL   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_READ  = 3'd1,
        ST_CALC  = 3'd2,
        ST_SQRT  = 3'd3,
        ST_OUT   = 3'd4
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item, start line store read
        logic shift;    // update window and counters
        logic sqrt_start;
        logic sqrt_step;
        logic finish;   // compose result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic ignore;   // early flush, no state change
        logic emit;
        logic sobel;
        logic sqrt_done;
    } t_status;

endpackage

// ===== rtl/s3f_ctrl.sv =====
`timescale 1ns / 1ps
module s3f_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    input  s3f_pkg::t_status i_status,
    output s3f_pkg::t_cmd    o_cmd
);

    s3f_pkg::t_state r_state, n_state;
    logic r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= s3f_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // output register is free when empty or being taken
    logic w_out_free;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            s3f_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = s3f_pkg::ST_READ;
            end
            s3f_pkg::ST_READ: begin
                if (i_status.ignore)    n_state = s3f_pkg::ST_IDLE;
                else if (!i_status.emit) n_state = s3f_pkg::ST_IDLE;
                else                     n_state = s3f_pkg::ST_CALC;
            end
            s3f_pkg::ST_CALC: begin
                n_state = i_status.sobel ? s3f_pkg::ST_SQRT : s3f_pkg::ST_OUT;
            end
            s3f_pkg::ST_SQRT: begin
                if (i_status.sqrt_done) n_state = s3f_pkg::ST_OUT;
            end
            s3f_pkg::ST_OUT: begin
                if (w_out_free) n_state = s3f_pkg::ST_IDLE;
            end
            default: n_state = s3f_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            s3f_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            s3f_pkg::ST_READ: begin
                o_cmd.shift = !i_status.ignore;
            end
            s3f_pkg::ST_CALC: begin
                o_cmd.sqrt_start = i_status.sobel;
            end
            s3f_pkg::ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
            end
            s3f_pkg::ST_OUT: begin
                if (w_out_free) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != s3f_pkg::ST_IDLE) |-> o_in_stall)
        else $error("input taken while busy");
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> w_out_free)
        else $error("result overwritten");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("stalled result dropped");
`endif

endmodule

// ===== rtl/s3f_datapath.sv =====
`timescale 1ns / 1ps
module s3f_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  s3f_pkg::t_in_item i_item,
    input  s3f_pkg::t_cmd     i_cmd,
    output s3f_pkg::t_status  o_status,
    output s3f_pkg::t_out_item o_item
);

    localparam int CW = s3f_pkg::ColW;
    localparam int RW = s3f_pkg::RowW;

    // configuration
    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [2:0]  r_mode;
    logic [10:0] r_thresh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd640;
            r_height <= 13'd480;
            r_mode   <= 3'd0;
            r_thresh <= 11'd0;
        end else if (i_cfg_we) begin
            unique case (s3f_pkg::t_reg_idx'(i_cfg_idx))
                s3f_pkg::REG_WIDTH:     r_width  <= i_cfg_data[10:0];
                s3f_pkg::REG_HEIGHT:    r_height <= i_cfg_data[12:0];
                s3f_pkg::REG_MODE:      r_mode   <= i_cfg_data[2:0];
                s3f_pkg::REG_THRESHOLD: r_thresh <= i_cfg_data[10:0];
                default: ;
            endcase
        end
    end

    // used geometry, width in 11 bits, height in 13 bits (4096 fits)
    logic [10:0] w_w;
    logic [12:0] w_h;
    always_comb begin
        w_w = r_width;
        if (r_width < 11'd3) w_w = 11'd3;
        else if (r_width > 11'(s3f_pkg::MaxWidth)) w_w = 11'(s3f_pkg::MaxWidth);
        w_h = r_height;
        if (r_height < 13'd3) w_h = 13'd3;
        else if (r_height > 13'(s3f_pkg::MaxHeight)) w_h = 13'(s3f_pkg::MaxHeight);
    end

    // counters
    logic [CW:0]   r_col;   // up to MaxWidth-1 normally, wider for width changes
    logic [RW-1:0] r_row;
    logic [CW-1:0] w_idx;
    assign w_idx = (r_col < (CW+1)'(s3f_pkg::MaxWidth)) ? r_col[CW-1:0]
                                                        : CW'(s3f_pkg::MaxWidth - 1);

    logic w_drain;
    assign w_drain = {1'b0, r_row} >= {1'b0, w_h};

    // captured item
    logic [31:0] r_px;
    logic        r_flush;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_px    <= {i_item.alpha, i_item.blue, i_item.green, i_item.red};
            r_flush <= i_item.flush;
        end
    end

    logic [31:0] w_px;
    assign w_px = w_drain ? 32'd0 : r_px;

    // line stores, read registered in load cycle
    logic [31:0] r_upper_mem [s3f_pkg::MaxWidth];
    logic [31:0] r_mid_mem   [s3f_pkg::MaxWidth];
    logic [31:0] r_up_rd, r_mid_rd;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_up_rd  <= r_upper_mem[w_idx];
            r_mid_rd <= r_mid_mem[w_idx];
        end
        if (i_cmd.shift) begin
            r_upper_mem[w_idx] <= r_mid_rd;
            r_mid_mem[w_idx]   <= w_px;
        end
    end

    // window
    logic [23:0] r_win [9];
    logic [7:0]  r_calpha, r_ralpha;
    logic        w_emit;
    logic [CW:0]   w_ox;
    logic [RW-1:0] w_oy;
    logic          w_last;
    logic [CW:0]   r_ox;
    logic [RW-1:0] r_oy;
    logic          r_last;

    assign w_emit = (r_row >= RW'(2)) || (r_row == RW'(1) && r_col != '0);
    always_comb begin
        if (r_col == '0) begin
            w_ox = (CW+1)'(w_w - 11'd1);
            w_oy = r_row - RW'(2);
        end else begin
            w_ox = r_col - (CW+1)'(1);
            w_oy = r_row - RW'(1);
        end
        w_last = (w_ox == (CW+1)'(w_w - 11'd1)) && (w_oy >= w_h - 13'd1)
                 && (r_row != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_calpha <= '0;
            r_ralpha <= '0;
            for (int i = 0; i < 9; i++) r_win[i] <= '0;
        end else if (i_cmd.shift) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i*3]   <= r_win[i*3+1];
                r_win[i*3+1] <= r_win[i*3+2];
            end
            r_win[2] <= r_up_rd[23:0];
            r_win[5] <= r_mid_rd[23:0];
            r_win[8] <= w_px[23:0];
            r_calpha <= r_ralpha;
            r_ralpha <= r_mid_rd[31:24];
            if (w_emit && w_last) begin
                r_col <= '0;
                r_row <= '0;
            end else if ({1'b0, r_col} + 12'd1 >= {1'b0, w_w}) begin
                r_col <= '0;
                r_row <= r_row + RW'(1);
            end else begin
                r_col <= r_col + (CW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_ox   <= w_ox;
            r_oy   <= w_oy;
            r_last <= w_last;
        end
    end

    // filter arithmetic on the shifted window, one channel per lane
    logic        w_border;
    assign w_border = (r_ox == '0) || ({1'b0, r_ox} + 12'd1 >= {1'b0, w_w})
                      || (r_oy == '0) || ({1'b0, r_oy} + 14'd1 >= {1'b0, w_h});

    logic [7:0] r_res [3];
    logic [7:0] w_res [3];
    logic signed [12:0] w_sum [3];

    // border pixels keep the center value
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic signed [12:0] p [9];
            for (int i = 0; i < 9; i++) p[i] = 13'(r_win[i][c*8 +: 8]);
            w_res[c] = r_win[4][c*8 +: 8];
            w_sum[c] = '0;
            if (!w_border) begin
                unique case (r_mode)
                    s3f_pkg::MODE_BOX: begin
                        w_sum[c] = p[0]+p[1]+p[2]+p[3]+p[4]+p[5]+p[6]+p[7]+p[8];
                        w_res[c] = 8'((24'(w_sum[c][11:0]) * 24'd7282) >> 16);
                    end
                    s3f_pkg::MODE_GAUSS: begin
                        w_sum[c] = p[0]+(p[1]<<<1)+p[2]+(p[3]<<<1)+(p[4]<<<2)
                                   +(p[5]<<<1)+p[6]+(p[7]<<<1)+p[8];
                        w_res[c] = w_sum[c][11:4];
                    end
                    s3f_pkg::MODE_SHARPEN, s3f_pkg::MODE_EMBOSS: begin
                        if (r_mode == s3f_pkg::MODE_SHARPEN)
                            w_sum[c] = (p[4]<<<2) + p[4] - p[1] - p[3] - p[5] - p[7];
                        else
                            w_sum[c] = p[5] + p[7] + p[8] - p[0] - p[1] - p[3]
                                       + 13'sd128;
                        if (w_sum[c] < 0) w_res[c] = 8'd0;
                        else if (w_sum[c] > 13'sd255) w_res[c] = 8'd255;
                        else w_res[c] = w_sum[c][7:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    // sobel gradient on red
    logic signed [11:0] w_gh, w_gv;
    always_comb begin
        logic signed [11:0] q [9];
        for (int i = 0; i < 9; i++) q[i] = 12'(r_win[i][7:0]);
        w_gh = q[0] - q[2] + (q[3]<<<1) - (q[5]<<<1) + q[6] - q[8];
        w_gv = q[6] + (q[7]<<<1) + q[8] - q[0] - (q[1]<<<1) - q[2];
    end

    // iterative square root, two bits per step
    logic [21:0] r_rem;
    logic [11:0] r_root;
    logic [3:0]  r_step;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= 4'd0;
        end else if (i_cmd.sqrt_start) begin
            r_step <= 4'd0;
        end else if (i_cmd.sqrt_step) begin
            r_step <= r_step + 4'd1;
        end
    end

    // remainder/root registers, restoring method over eleven pairs of bits
    logic [23:0] r_acc;
    logic [23:0] w_acc_sh;
    assign w_acc_sh = r_acc << 2;
    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_acc  <= 24'(22'($signed(w_gh) * $signed(w_gh))
                          + 22'($signed(w_gv) * $signed(w_gv)));
        end else if (i_cmd.sqrt_step && r_step != 4'd11) begin
            logic [13:0] rem_n;
            logic [13:0] t;
            rem_n = {r_rem[11:0], r_acc[21:20]};
            t     = {r_root, 2'b01};
            r_acc <= w_acc_sh;
            if (rem_n >= t) begin
                r_rem  <= 22'(rem_n - t);
                r_root <= {r_root[10:0], 1'b1};
            end else begin
                r_rem  <= 22'(rem_n);
                r_root <= {r_root[10:0], 1'b0};
            end
        end
    end

    logic [7:0] w_mag;
    always_comb begin
        if (r_root <= 12'(r_thresh)) w_mag = 8'd0;
        else if (r_root > 12'd255) w_mag = 8'd255;
        else w_mag = r_root[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start || !i_cmd.sqrt_step) begin
            for (int c = 0; c < 3; c++) r_res[c] <= w_res[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_item.frame_last <= r_last;
            o_item.out_alpha  <= r_calpha;
            if (!w_border && r_mode == s3f_pkg::MODE_SOBEL) begin
                o_item.out_red   <= w_mag;
                o_item.out_green <= w_mag;
                o_item.out_blue  <= w_mag;
            end else begin
                o_item.out_red   <= r_res[0];
                o_item.out_green <= r_res[1];
                o_item.out_blue  <= r_res[2];
            end
        end
    end

    assign o_status.ignore    = r_flush && !w_drain;
    assign o_status.emit      = w_emit;
    assign o_status.sobel     = (r_mode == s3f_pkg::MODE_SOBEL) && !w_border;
    assign o_status.sqrt_done = (r_step == 4'd11);

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift |=> (r_col < (CW+1)'(s3f_pkg::MaxWidth)))
        else $error("column out of range");
    a_root_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == 4'd11) |-> (r_root <= 12'd1443))
        else $error("root too large");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.load && i_cmd.shift))
        else $error("load during shift");
`endif

endmodule

// ===== rtl/stencil_3x3_image_filter.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake        | payload
// in      | input     | valid / stall    | s3f_pkg::t_in_item
// out     | output    | valid / stall    | s3f_pkg::t_out_item
// cfg     | input     | valid / ready    | index 2 bits, data 32 bits
//
// an item with no result is accepted with the line store read, then shifts the window
// a filtered result then passes the calc and output states; sobel adds the
// square root state for the two-bit-per-step square root unit
// reset is synchronous active low; line stores are not cleared
// a stalled result holds in the output register; the next result waits behind it
// and holds off further input
module stencil_3x3_image_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  s3f_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output s3f_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    s3f_pkg::t_cmd    w_cmd;
    s3f_pkg::t_status w_status;

    assign o_cfg_ready = 1'b1;

    s3f_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    s3f_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_idx  (i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_item     (i_in_data),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .o_item     (o_out_data)
    );

endmodule

// ===== bench/stencil_3x3_checker.sv =====
`timescale 1ns / 1ps
module stencil_3x3_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  s3f_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  s3f_pkg::t_out_item i_out_data,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked
);

    s3f_pkg::t_out_item pixel_queue[$];

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  mode_reg;
    logic [10:0] thresh_reg;

    logic [31:0] upper_line [s3f_pkg::MaxWidth];
    logic [31:0] middle_line [s3f_pkg::MaxWidth];
    logic [23:0] win [9];
    logic [7:0]  ctr_alpha;
    logic [7:0]  right_alpha;
    int          col;
    int          row;
    int          coef [6][9];

    initial begin
        coef = '{'{1, 1, 1, 1, 1, 1, 1, 1, 1},
                 '{1, 2, 1, 2, 4, 2, 1, 2, 1},
                 '{0, -1, 0, -1, 5, -1, 0, -1, 0},
                 '{-1, -1, 0, -1, 0, 1, 0, 1, 1},
                 '{1, 0, -1, 2, 0, -2, 1, 0, -1},
                 '{-1, -2, -1, 0, 0, 0, 1, 2, 1}};
    end

    function automatic int kernel_sum(input int k, input int sh);
        int s;
        s = 0;
        for (int i = 0; i < 9; i++) begin
            s += int'((win[i] >> sh) & 24'hFF) * coef[k][i];
        end
        return s;
    endfunction

    function automatic logic [7:0] sat8(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic int floor_sqrt(input int n);
        int r;
        r = 0;
        for (int b = 15; b >= 0; b--) begin
            if ((r | (1 << b)) * (r | (1 << b)) <= n) r = r | (1 << b);
        end
        return r;
    endfunction

    task automatic filter_pixel(input s3f_pkg::t_in_item it);
        int                 w, h, c, r, idx, ox, oy, hs, vs, mag;
        logic [31:0]        px, up, mid;
        logic               drain, emit, last;
        s3f_pkg::t_out_item res;
        w = (width_reg < 3) ? 3 : ((width_reg > s3f_pkg::MaxWidth) ? s3f_pkg::MaxWidth
                                                                   : int'(width_reg));
        h = (height_reg < 3) ? 3 : ((height_reg > s3f_pkg::MaxHeight) ? s3f_pkg::MaxHeight
                                                                      : int'(height_reg));
        c = col;
        r = row;
        drain = (r >= h);
        if (it.flush && !drain) return;
        px = drain ? 32'd0 : {it.alpha, it.blue, it.green, it.red};
        idx = (c < s3f_pkg::MaxWidth) ? c : s3f_pkg::MaxWidth - 1;
        up = upper_line[idx];
        mid = middle_line[idx];
        upper_line[idx] = mid;
        middle_line[idx] = px;
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = up[23:0];
        win[5] = mid[23:0];
        win[8] = px[23:0];
        ctr_alpha = right_alpha;
        right_alpha = mid[31:24];
        emit = (r >= 2) || (r == 1 && c >= 1);
        if (c == 0) begin
            ox = w - 1;
            oy = r - 2;
        end else begin
            ox = c - 1;
            oy = r - 1;
        end
        if (c + 1 >= w) begin
            col = 0;
            row = (r + 1) & 32'h1FFF;
        end else begin
            col = c + 1;
        end
        if (!emit) return;
        res.out_red = win[4][7:0];
        res.out_green = win[4][15:8];
        res.out_blue = win[4][23:16];
        if (!(ox == 0 || ox + 1 >= w || oy == 0 || oy + 1 >= h)) begin
            case (mode_reg)
                s3f_pkg::MODE_BOX: begin
                    res.out_red = 8'(kernel_sum(0, 0) / 9);
                    res.out_green = 8'(kernel_sum(0, 8) / 9);
                    res.out_blue = 8'(kernel_sum(0, 16) / 9);
                end
                s3f_pkg::MODE_GAUSS: begin
                    res.out_red = 8'(kernel_sum(1, 0) / 16);
                    res.out_green = 8'(kernel_sum(1, 8) / 16);
                    res.out_blue = 8'(kernel_sum(1, 16) / 16);
                end
                s3f_pkg::MODE_SHARPEN: begin
                    res.out_red = sat8(kernel_sum(2, 0));
                    res.out_green = sat8(kernel_sum(2, 8));
                    res.out_blue = sat8(kernel_sum(2, 16));
                end
                s3f_pkg::MODE_EMBOSS: begin
                    res.out_red = sat8(kernel_sum(3, 0) + 128);
                    res.out_green = sat8(kernel_sum(3, 8) + 128);
                    res.out_blue = sat8(kernel_sum(3, 16) + 128);
                end
                s3f_pkg::MODE_SOBEL: begin
                    hs = kernel_sum(4, 0);
                    vs = kernel_sum(5, 0);
                    mag = floor_sqrt(hs * hs + vs * vs);
                    if (mag <= int'(thresh_reg)) mag = 0;
                    if (mag > 255) mag = 255;
                    res.out_red = mag[7:0];
                    res.out_green = mag[7:0];
                    res.out_blue = mag[7:0];
                end
                default: ;
            endcase
        end
        last = (ox == w - 1) && (oy >= h - 1) && (r >= 1);
        res.out_alpha = ctr_alpha;
        res.frame_last = last;
        if (last) begin
            col = 0;
            row = 0;
        end
        pixel_queue.push_back(res);
    endtask

    task automatic report_field(input string name, input int exp_v, input int got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        s3f_pkg::t_out_item exp_item;
        if (!i_rst_n) begin
            width_reg = 11'd640;
            height_reg = 13'd480;
            mode_reg = 3'd0;
            thresh_reg = 11'd0;
            for (int i = 0; i < s3f_pkg::MaxWidth; i++) begin
                upper_line[i] = 32'd0;
                middle_line[i] = 32'd0;
            end
            for (int i = 0; i < 9; i++) win[i] = 24'd0;
            ctr_alpha = 8'd0;
            right_alpha = 8'd0;
            col = 0;
            row = 0;
            pixel_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (s3f_pkg::t_reg_idx'(i_cfg_index))
                    s3f_pkg::REG_WIDTH:     width_reg = i_cfg_data[10:0];
                    s3f_pkg::REG_HEIGHT:    height_reg = i_cfg_data[12:0];
                    s3f_pkg::REG_MODE:      mode_reg = i_cfg_data[2:0];
                    s3f_pkg::REG_THRESHOLD: thresh_reg = i_cfg_data[10:0];
                    default: ;
                endcase
            end
            // result handshake checked before the new transaction is predicted
            if (i_out_valid && !i_out_stall) begin
                if (pixel_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, i_out_data);
                    o_fail_count++;
                end else begin
                    exp_item = pixel_queue.pop_front();
                    report_field("out_red", exp_item.out_red, i_out_data.out_red);
                    report_field("out_green", exp_item.out_green, i_out_data.out_green);
                    report_field("out_blue", exp_item.out_blue, i_out_data.out_blue);
                    report_field("out_alpha", exp_item.out_alpha, i_out_data.out_alpha);
                    report_field("frame_last", exp_item.frame_last, i_out_data.frame_last);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) filter_pixel(i_in_data);
        end
        o_pending = pixel_queue.size();
    end

endmodule

// ===== bench/tb_stencil_3x3_image_filter.sv =====
`timescale 1ns / 1ps
module tb_stencil_3x3_image_filter;

    localparam int IdleLimit = 3000;

    logic               i_clk;
    logic               i_rst_n;
    logic               in_valid;
    logic               in_stall;
    s3f_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_stall = 1'b0;
    s3f_pkg::t_out_item out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;

    int fail_count;
    int pending;
    int checked;
    int quiet;
    int stall_left;
    int idle_cycles;
    int pixel_total;
    int frames;
    bit out_taken;

    stencil_3x3_image_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    stencil_3x3_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side back-pressure, redrawn after every result transaction
    always @(negedge i_clk) begin
        if (out_taken) stall_left = quiet ? 0 : $urandom_range(0, 19);
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        out_taken = out_valid && !out_stall;
        if ((in_valid && !in_stall) || out_taken || (cfg_valid && cfg_ready)
            || !i_rst_n) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog expired at %0t", $time);
            $display("tb_stencil_3x3_image_filter NOT OK");
            $finish;
        end
    end

    // leaves valid high, the caller drops it after the last write
    task automatic write_reg(input s3f_pkg::t_reg_idx idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
    endtask

    // called at a falling edge; leaves valid high, the next call drops it for a nonzero gap
    task automatic send_item(input s3f_pkg::t_in_item it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        pixel_total++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(negedge i_clk);
    endtask

    // pattern 0 random, 1 channels at 0 or 255, 2 all zero, 3 all ones
    task automatic run_frame(input int wraw, input int hraw, input int mode, input int thr,
                             input int pattern, input logic pause_mid);
        int                w, h, n;
        s3f_pkg::t_in_item it;
        w = (wraw < 3) ? 3 : ((wraw > s3f_pkg::MaxWidth) ? s3f_pkg::MaxWidth : wraw);
        h = (hraw < 3) ? 3 : ((hraw > s3f_pkg::MaxHeight) ? s3f_pkg::MaxHeight : hraw);
        write_reg(s3f_pkg::REG_WIDTH, 32'(wraw));
        write_reg(s3f_pkg::REG_HEIGHT, 32'(hraw));
        write_reg(s3f_pkg::REG_MODE, 32'(mode));
        write_reg(s3f_pkg::REG_THRESHOLD, 32'(thr));
        cfg_valid <= 1'b0;
        n = 0;
        while (n < w * h) begin
            it.red = 8'($urandom);
            it.green = 8'($urandom);
            it.blue = 8'($urandom);
            it.alpha = 8'($urandom);
            if (pattern == 1) begin
                it.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                it.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                it.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            if (pattern == 2) it[32:1] = 32'h0;
            if (pattern == 3) it[32:1] = 32'hFFFFFFFF;
            // an early flush is dropped by the block
            it.flush = ($urandom_range(0, 14) == 0);
            send_item(it);
            if (!it.flush) n++;
            if (pause_mid && n == (w * h) / 2) begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(negedge i_clk);
            end
        end
        // drain the last row, stray pixel data is discarded
        for (int i = 0; i <= w; i++) begin
            it[32:1] = $urandom;
            it.flush = 1'($urandom_range(0, 1));
            send_item(it);
        end
        // flushes at the start of a frame are ignored
        if ($urandom_range(0, 3) == 0) begin
            it[32:1] = $urandom;
            it.flush = 1'b1;
            send_item(it);
        end
        settle();
        frames++;
    endtask

    initial begin
        int wr, hr, md;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = s3f_pkg::REG_WIDTH;
        cfg_data = 32'd0;
        quiet = 0;
        pixel_total = 0;
        frames = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed frames: extreme values, every mode, small geometry limits
        run_frame(3, 3, s3f_pkg::MODE_BOX, 0, 3, 1'b0);
        run_frame(0, 0, s3f_pkg::MODE_SHARPEN, 0, 2, 1'b0);
        run_frame(4, 4, s3f_pkg::MODE_SOBEL, 0, 1, 1'b1);
        run_frame(5, 4, s3f_pkg::MODE_SOBEL, 1443, 1, 1'b0);
        quiet = 1;
        run_frame(4, 5, s3f_pkg::MODE_EMBOSS, 0, 1, 1'b0);
        quiet = 0;
        run_frame(3, 4, s3f_pkg::MODE_GAUSS, 0, 3, 1'b0);
        run_frame(4, 3, 7, 2047, 0, 1'b0);

        while (pixel_total < 1350) begin
            quiet = ($urandom_range(0, 4) == 0);
            wr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            hr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            md = $urandom_range(0, 7);
            if ($urandom_range(0, 3) == 0) md = s3f_pkg::MODE_SOBEL;
            run_frame(wr, hr, md,
                      $urandom_range(0, 1) ? $urandom_range(0, 300) : $urandom_range(0, 1443),
                      ($urandom_range(0, 5) == 0) ? 1 : 0, $urandom_range(0, 9) == 0);
        end
        quiet = 0;

        wait (pending == 0);
        repeat (60) @(negedge i_clk);
        $display("%0d frames over all filter modes and small geometries, %0d items sent",
                 frames, pixel_total);
        $display("%0d results compared, %0d mismatches", checked, fail_count);
        if (fail_count == 0) begin
            $display("tb_stencil_3x3_image_filter OK");
        end else begin
            $display("tb_stencil_3x3_image_filter NOT OK");
        end
        $finish;
    end

endmodule
